FILE: sv/okle_pkg.sv
// Package: shared types, codes and constants for the ordered key list engine.
package okle_pkg;

  localparam int unsigned CAPACITY_DEF = 64;

  localparam logic [2:0] OP_PUSH_FRONT = 3'd0;
  localparam logic [2:0] OP_PUSH_BACK  = 3'd1;
  localparam logic [2:0] OP_DELETE     = 3'd2;
  localparam logic [2:0] OP_INS_AFTER  = 3'd3;
  localparam logic [2:0] OP_INS_BEFORE = 3'd4;
  localparam logic [2:0] OP_POP_FRONT  = 3'd5;
  localparam logic [2:0] OP_POP_BACK   = 3'd6;
  localparam logic [2:0] OP_LIST       = 3'd7;

  localparam logic [2:0] KIND_KEY      = 3'd0;
  localparam logic [2:0] KIND_EMPTY    = 3'd1;
  localparam logic [2:0] KIND_ABSENT   = 3'd2;
  localparam logic [2:0] KIND_LASTGONE = 3'd3;
  localparam logic [2:0] KIND_FULL     = 3'd4;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_WALK,
    ST_WALKCHK,
    ST_DELNEXT,
    ST_DELKEY,
    ST_EMIT,
    ST_LIST,
    ST_LISTOUT
  } state_t;

  // Result beat handed to the output register.
  typedef struct packed {
    logic [2:0] kind;
    logic [7:0] key;
    logic       last;
  } res_t;

endpackage

FILE: sv/okle_store.sv
// Key and link memories, synchronous write and registered read.
module okle_store #(
  parameter int unsigned DEPTH = okle_pkg::CAPACITY_DEF,
  parameter int unsigned AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic          clk,
  input  logic [AW-1:0] rd_addr,
  output logic [7:0]    rd_key,
  output logic [AW-1:0] rd_link,
  input  logic          key_we,
  input  logic [AW-1:0] key_waddr,
  input  logic [7:0]    key_wdata,
  input  logic          link_we,
  input  logic [AW-1:0] link_waddr,
  input  logic [AW-1:0] link_wdata
);

  logic [7:0]    key_mem  [DEPTH];
  logic [AW-1:0] link_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (key_we) begin
      key_mem[key_waddr] <= key_wdata;
    end
    rd_key <= key_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (link_we) begin
      link_mem[link_waddr] <= link_wdata;
    end
    rd_link <= link_mem[rd_addr];
  end

endmodule

FILE: sv/ordered_key_list_engine.sv
// Top level: ordered key list engine, a linked list of byte keys in memory.
// Push front and empty status take no walk; push back adds an old tail link fix-up;
// other ops walk the list entry by entry, delete also reads its follower's key, an
// insert adds a link fix-up. One item at a time; input stalls during a walk or fix-up
// and while a result waits. Sync reset (rst high) empties the list, frees all slots.
module ordered_key_list_engine #(
  parameter int unsigned CAPACITY = okle_pkg::CAPACITY_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] opcode,
  input  logic [7:0] item_key,
  input  logic [7:0] anchor_key,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [2:0] kind,
  output logic [7:0] key_out,
  output logic       last
);

  localparam int unsigned AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);

  okle_pkg::state_t state, state_next;

  logic [2:0]    op;
  logic [7:0]    ikey, akey;
  logic [AW-1:0] head, tail;
  logic [CW-1:0] count;
  logic [CAPACITY-1:0] free_map;
  logic [AW-1:0] cur, prev;
  logic          has_prev;
  logic [CW-1:0] steps;

  logic [AW-1:0] rd_addr;
  logic [7:0]    rd_key;
  logic [AW-1:0] rd_link;
  logic          key_we, link_we;
  logic [AW-1:0] key_waddr, link_waddr, link_wdata;
  logic [7:0]    key_wdata;

  logic          res_valid;
  okle_pkg::res_t res, res_next;
  logic          res_load;

  logic          slot_found;
  logic [AW-1:0] slot;
  logic [CAPACITY-1:0] free_set, free_clr;

  // second link write for inserts and push back, in the cycle after the new slot is written
  logic          fix_we;
  logic [AW-1:0] fix_addr, fix_data;
  logic          fix_pend;
  logic [AW-1:0] fix_paddr, fix_pdata;

  logic          accept;
  assign accept   = in_valid && !in_stall;
  assign in_stall = (state != okle_pkg::ST_IDLE) || fix_pend || (res_valid && out_stall);

  // lowest free slot
  always_comb begin
    slot_found = 1'b0;
    slot = '0;
    for (int i = CAPACITY - 1; i >= 0; i--) begin
      if (free_map[i]) begin
        slot_found = 1'b1;
        slot = AW'(i);
      end
    end
  end

  logic out_free;
  assign out_free = !res_valid || !out_stall;
  assign rd_addr  = (state == okle_pkg::ST_IDLE) ? head : cur;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      okle_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (opcode)
            okle_pkg::OP_PUSH_FRONT, okle_pkg::OP_PUSH_BACK: state_next = okle_pkg::ST_IDLE;
            default: state_next = (count == '0) ? okle_pkg::ST_IDLE : okle_pkg::ST_WALK;
          endcase
        end
      end
      okle_pkg::ST_WALK: state_next = okle_pkg::ST_WALKCHK;
      okle_pkg::ST_WALKCHK: begin
        state_next = okle_pkg::ST_IDLE;
        unique case (op)
          okle_pkg::OP_LIST: state_next = okle_pkg::ST_LISTOUT;
          okle_pkg::OP_POP_FRONT: state_next = okle_pkg::ST_IDLE;
          okle_pkg::OP_POP_BACK:
            if (steps != count) state_next = okle_pkg::ST_WALK;
          okle_pkg::OP_DELETE: begin
            if (rd_key == ikey) begin
              if (cur != tail) state_next = okle_pkg::ST_DELNEXT;
            end else if (steps != count) begin
              state_next = okle_pkg::ST_WALK;
            end
          end
          default:
            if (rd_key != akey && steps != count) state_next = okle_pkg::ST_WALK;
        endcase
      end
      okle_pkg::ST_DELNEXT: state_next = okle_pkg::ST_DELKEY;
      okle_pkg::ST_DELKEY: state_next = okle_pkg::ST_IDLE;
      okle_pkg::ST_LISTOUT:
        if (out_free) state_next = (steps == count) ? okle_pkg::ST_IDLE : okle_pkg::ST_LIST;
      okle_pkg::ST_LIST: state_next = okle_pkg::ST_LISTOUT;
      default: state_next = okle_pkg::ST_IDLE;
    endcase
  end

  logic [7:0] list_key;

  // datapath actions
  always_comb begin
    key_we = 1'b0; key_waddr = slot; key_wdata = ikey;
    link_we = 1'b0; link_waddr = slot; link_wdata = '0;
    free_set = '0; free_clr = '0;
    res_load = 1'b0;
    res_next = '{kind: okle_pkg::KIND_KEY, key: 8'd0, last: 1'b1};
    unique case (state)
      okle_pkg::ST_IDLE: begin
        if (accept) begin
          unique case (opcode)
            okle_pkg::OP_PUSH_FRONT, okle_pkg::OP_PUSH_BACK: begin
              if (!slot_found) begin
                res_load = 1'b1;
                res_next.kind = okle_pkg::KIND_FULL;
              end else begin
                key_we = 1'b1; key_wdata = item_key;
                free_clr[slot] = 1'b1;
                link_we = 1'b1;
                link_wdata = (opcode == okle_pkg::OP_PUSH_FRONT && count != '0) ? head : '0;
              end
            end
            default: begin
              if (count == '0) begin
                res_load = 1'b1;
                res_next.kind = okle_pkg::KIND_EMPTY;
              end
            end
          endcase
        end
      end
      okle_pkg::ST_WALKCHK: begin
        unique case (op)
          okle_pkg::OP_POP_FRONT, okle_pkg::OP_POP_BACK: begin
            if (op == okle_pkg::OP_POP_FRONT || steps == count) begin
              res_load = 1'b1;
              res_next.key = rd_key;
              free_set[cur] = 1'b1;
            end
          end
          okle_pkg::OP_DELETE: begin
            if (rd_key == ikey) begin
              free_set[cur] = 1'b1;
              if (has_prev) begin
                link_we = 1'b1; link_waddr = prev; link_wdata = rd_link;
              end
              if (cur == tail) begin
                res_load = 1'b1;
                res_next.kind = okle_pkg::KIND_LASTGONE;
              end
            end else if (steps == count) begin
              res_load = 1'b1;
              res_next.kind = okle_pkg::KIND_ABSENT;
            end
          end
          okle_pkg::OP_INS_AFTER, okle_pkg::OP_INS_BEFORE: begin
            if (rd_key == akey) begin
              if (!slot_found) begin
                res_load = 1'b1;
                res_next.kind = okle_pkg::KIND_FULL;
              end else begin
                key_we = 1'b1;
                free_clr[slot] = 1'b1;
                link_we = 1'b1;
                link_waddr = slot;
                link_wdata = (op == okle_pkg::OP_INS_AFTER) ? rd_link : cur;
              end
            end else if (steps == count) begin
              res_load = 1'b1;
              res_next.kind = okle_pkg::KIND_ABSENT;
            end
          end
          default: ;
        endcase
      end
      okle_pkg::ST_DELKEY: begin
        res_load = 1'b1;
        res_next.key = rd_key;
      end
      okle_pkg::ST_LISTOUT: begin
        if (out_free) begin
          res_load = 1'b1;
          res_next.key = list_key;
          res_next.last = (steps == count);
        end
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= okle_pkg::ST_IDLE;
      head <= '0; tail <= '0; count <= '0;
      free_map <= '1;
      res_valid <= 1'b0;
      fix_pend <= 1'b0;
    end else begin
      state <= state_next;
      free_map <= (free_map | free_set) & ~free_clr;
      fix_pend <= 1'b0;
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (!out_stall) begin
        res_valid <= 1'b0;
      end
      if (state == okle_pkg::ST_IDLE && accept) begin
        if ((opcode == okle_pkg::OP_PUSH_FRONT || opcode == okle_pkg::OP_PUSH_BACK)
            && slot_found) begin
          count <= count + CW'(1);
          if (count == '0) begin
            head <= slot; tail <= slot;
          end else if (opcode == okle_pkg::OP_PUSH_FRONT) begin
            head <= slot;
          end else begin
            tail <= slot;
            fix_pend <= 1'b1; fix_paddr <= tail; fix_pdata <= slot;
          end
        end
      end
      if (state == okle_pkg::ST_WALKCHK) begin
        unique case (op)
          okle_pkg::OP_POP_FRONT, okle_pkg::OP_POP_BACK, okle_pkg::OP_DELETE: begin
            if ((op == okle_pkg::OP_DELETE && rd_key == ikey)
                || op == okle_pkg::OP_POP_FRONT
                || (op == okle_pkg::OP_POP_BACK && steps == count)) begin
              count <= count - CW'(1);
              if (count == CW'(1)) begin
                head <= '0; tail <= '0;
              end else begin
                if (!has_prev) head <= rd_link;
                if (cur == tail && has_prev) tail <= prev;
              end
            end
          end
          okle_pkg::OP_INS_AFTER, okle_pkg::OP_INS_BEFORE: begin
            if (rd_key == akey && slot_found) begin
              count <= count + CW'(1);
              if (op == okle_pkg::OP_INS_AFTER) begin
                fix_pend <= 1'b1; fix_paddr <= cur; fix_pdata <= slot;
                if (cur == tail) tail <= slot;
              end else if (!has_prev) begin
                head <= slot;
              end else begin
                fix_pend <= 1'b1; fix_paddr <= prev; fix_pdata <= slot;
              end
            end
          end
          default: ;
        endcase
      end
    end
  end

  assign fix_we   = fix_pend;
  assign fix_addr = fix_paddr;
  assign fix_data = fix_pdata;

  logic          link_we_m;
  logic [AW-1:0] link_waddr_m, link_wdata_m;
  assign link_we_m    = link_we || fix_we;
  assign link_waddr_m = fix_we ? fix_addr : link_waddr;
  assign link_wdata_m = fix_we ? fix_data : link_wdata;

  okle_store #(.DEPTH(CAPACITY), .AW(AW)) u_store (
    .clk(clk), .rd_addr(rd_addr), .rd_key(rd_key), .rd_link(rd_link),
    .key_we(key_we), .key_waddr(key_waddr), .key_wdata(key_wdata),
    .link_we(link_we_m), .link_waddr(link_waddr_m), .link_wdata(link_wdata_m)
  );

  // walk registers
  always_ff @(posedge clk) begin
    if (state == okle_pkg::ST_IDLE && accept) begin
      op <= opcode; ikey <= item_key; akey <= anchor_key;
      cur <= head; has_prev <= 1'b0; steps <= CW'(1);
    end else if (state == okle_pkg::ST_WALKCHK) begin
      list_key <= rd_key;
      if (state_next == okle_pkg::ST_WALK) begin
        prev <= cur; has_prev <= 1'b1; cur <= rd_link; steps <= steps + CW'(1);
      end else if (state_next == okle_pkg::ST_DELNEXT) begin
        cur <= rd_link;
      end else if (state_next == okle_pkg::ST_LISTOUT) begin
        cur <= rd_link;
      end
    end else if (state == okle_pkg::ST_LIST) begin
      list_key <= rd_key;
      cur <= rd_link;
    end else if (state == okle_pkg::ST_LISTOUT && out_free && steps != count) begin
      steps <= steps + CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) res <= res_next;
  end

  assign out_valid = res_valid;
  assign kind      = res.kind;
  assign key_out   = res.key;
  assign last      = res.last;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(kind) && $stable(key_out) && $stable(last));
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    state != okle_pkg::ST_IDLE |-> in_stall);
  a_count_range: assert property (@(posedge clk) disable iff (rst)
    count <= CW'(CAPACITY));
  a_link_port: assert property (@(posedge clk) disable iff (rst)
    !(fix_we && link_we));

endmodule

FILE: sim/ordered_key_list_engine_tb.sv
// Testbench for the ordered key list engine: directed table, random ops, predicted results.
`timescale 1ns / 100ps
module ordered_key_list_engine_tb;

  localparam int CAP = okle_pkg::CAPACITY_DEF;
  localparam int WATCHDOG = 40000;

  typedef struct {
    logic [2:0] kind;
    logic [7:0] key;
    logic       last;
  } beat_t;

  typedef struct {
    logic [2:0] op;
    logic [7:0] item;
    logic [7:0] anchor;
    bit         typed;
    logic [2:0] kind;
    logic [7:0] key;
  } row_t;

  logic clk = 0, rst = 1;
  logic in_valid = 0, out_stall = 0;
  logic [2:0] opcode = '0;
  logic [7:0] item_key = '0, anchor_key = '0;
  logic in_stall, out_valid, last;
  logic [2:0] kind;
  logic [7:0] key_out;

  ordered_key_list_engine uut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .item_key(item_key), .anchor_key(anchor_key),
    .out_valid(out_valid), .out_stall(out_stall),
    .kind(kind), .key_out(key_out), .last(last)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // predictor state: the list kept as an ordered queue of keys
  logic [7:0] seq_keys[$];
  beat_t pending[$];
  beat_t typed_q[$];
  int mismatches = 0, beats_seen = 0, items_sent = 0, lists_seen = 0;
  int fulls_seen = 0, idle_cycles = 0;
  int send_idle_pct = 0, recv_idle_pct = 0;
  bit timed_out = 0;

  function automatic beat_t mk(input logic [2:0] k, input logic [7:0] v, input logic l);
    beat_t b;
    b.kind = k; b.key = v; b.last = l;
    return b;
  endfunction

  function automatic int find_first(input logic [7:0] v);
    for (int i = 0; i < seq_keys.size(); i++) if (seq_keys[i] == v) return i;
    return -1;
  endfunction

  task automatic predict_op(input logic [2:0] op, input logic [7:0] itm, input logic [7:0] anc);
    int p;
    if (op == okle_pkg::OP_PUSH_FRONT || op == okle_pkg::OP_PUSH_BACK) begin
      if (seq_keys.size() >= CAP) begin
        pending.push_back(mk(okle_pkg::KIND_FULL, 0, 1)); fulls_seen++;
      end else if (op == okle_pkg::OP_PUSH_FRONT) seq_keys.push_front(itm);
      else seq_keys.push_back(itm);
      return;
    end
    if (seq_keys.size() == 0) begin
      pending.push_back(mk(okle_pkg::KIND_EMPTY, 0, 1));
      return;
    end
    case (op)
      okle_pkg::OP_DELETE: begin
        p = find_first(itm);
        if (p < 0) pending.push_back(mk(okle_pkg::KIND_ABSENT, 0, 1));
        else if (p == seq_keys.size() - 1) begin
          seq_keys.delete(p); pending.push_back(mk(okle_pkg::KIND_LASTGONE, 0, 1));
        end else begin
          pending.push_back(mk(okle_pkg::KIND_KEY, seq_keys[p + 1], 1)); seq_keys.delete(p);
        end
      end
      okle_pkg::OP_INS_AFTER, okle_pkg::OP_INS_BEFORE: begin
        p = find_first(anc);
        if (p < 0) pending.push_back(mk(okle_pkg::KIND_ABSENT, 0, 1));
        else if (seq_keys.size() >= CAP) begin
          pending.push_back(mk(okle_pkg::KIND_FULL, 0, 1)); fulls_seen++;
        end else seq_keys.insert(op == okle_pkg::OP_INS_AFTER ? p + 1 : p, itm);
      end
      okle_pkg::OP_POP_FRONT:
        pending.push_back(mk(okle_pkg::KIND_KEY, seq_keys.pop_front(), 1));
      okle_pkg::OP_POP_BACK:
        pending.push_back(mk(okle_pkg::KIND_KEY, seq_keys.pop_back(), 1));
      default: begin
        lists_seen++;
        for (int i = 0; i < seq_keys.size(); i++)
          pending.push_back(mk(okle_pkg::KIND_KEY, seq_keys[i], i == seq_keys.size() - 1));
      end
    endcase
  endtask

  // called at a falling edge; leaves valid high so beats can follow back to back
  task automatic send_beat(input logic [2:0] op, input logic [7:0] itm, input logic [7:0] anc);
    while (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      in_valid <= 0;
      @(negedge clk);
    end
    opcode <= op; item_key <= itm; anchor_key <= anc; in_valid <= 1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    predict_op(op, itm, anc);
    items_sent++;
    @(negedge clk);
  endtask

  // keys drawn from a small pool mostly, so searches hit
  function automatic logic [7:0] pick_key();
    if ($urandom_range(3) != 0) return 8'($urandom_range(15));
    return 8'($urandom);
  endfunction

  task automatic random_beat();
    int r;
    logic [2:0] op;
    r = $urandom_range(99);
    if (r < 22) op = okle_pkg::OP_PUSH_BACK;
    else if (r < 36) op = okle_pkg::OP_PUSH_FRONT;
    else if (r < 50) op = okle_pkg::OP_INS_AFTER;
    else if (r < 62) op = okle_pkg::OP_INS_BEFORE;
    else if (r < 75) op = okle_pkg::OP_DELETE;
    else if (r < 83) op = okle_pkg::OP_POP_FRONT;
    else if (r < 91) op = okle_pkg::OP_POP_BACK;
    else op = okle_pkg::OP_LIST;
    if ((op == okle_pkg::OP_INS_AFTER || op == okle_pkg::OP_INS_BEFORE
         || op == okle_pkg::OP_DELETE) && seq_keys.size() > 0 && $urandom_range(3) != 0)
      send_beat(op, op == okle_pkg::OP_DELETE ? seq_keys[$urandom_range(seq_keys.size() - 1)]
                : pick_key(), seq_keys[$urandom_range(seq_keys.size() - 1)]);
    else send_beat(op, pick_key(), pick_key());
  endtask

  task automatic drain();
    in_valid <= 0;
    while (pending.size() != 0) @(negedge clk);
    repeat (2 * CAP + 10) @(negedge clk);
  endtask

  // result side
  always @(negedge clk)
    out_stall <= (recv_idle_pct != 0) && ($urandom_range(99) < recv_idle_pct);

  always @(posedge clk) begin
    beat_t e;
    if (!rst && out_valid && !out_stall) begin
      beats_seen++;
      if (pending.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected beat kind=%0d key=%0d last=%0b",
                                       kind, key_out, last);
      end else begin
        e = pending.pop_front();
        if (e.kind !== kind || e.key !== key_out || e.last !== last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("mismatch: exp kind=%0d key=%0d last=%0b, got kind=%0d key=%0d last=%0b",
                     e.kind, e.key, e.last, kind, key_out, last);
        end
        if (typed_q.size() != 0) begin
          e = typed_q.pop_front();
          if (e.kind !== kind || e.key !== key_out) begin
            mismatches++;
            if (mismatches <= 10)
              $display("table mismatch: exp kind=%0d key=%0d, got kind=%0d key=%0d",
                       e.kind, e.key, kind, key_out);
          end
        end
      end
    end
  end

  // watchdog on cycles with no accepted beat
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG && !timed_out) begin
      timed_out = 1;
      $display("watchdog expired, %0d results outstanding", pending.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  row_t table_rows[$];

  function automatic row_t r(input logic [2:0] op, input logic [7:0] i, input logic [7:0] a,
                             input bit t = 0, input logic [2:0] k = 0, input logic [7:0] v = 0);
    row_t x;
    x.op = op; x.item = i; x.anchor = a; x.typed = t; x.kind = k; x.key = v;
    return x;
  endfunction

  initial begin
    table_rows = {
      r(okle_pkg::OP_POP_FRONT, 0, 0, 1, okle_pkg::KIND_EMPTY, 0),
      r(okle_pkg::OP_POP_BACK, 0, 0, 1, okle_pkg::KIND_EMPTY, 0),
      r(okle_pkg::OP_DELETE, 8'hff, 0, 1, okle_pkg::KIND_EMPTY, 0),
      r(okle_pkg::OP_INS_AFTER, 1, 2, 1, okle_pkg::KIND_EMPTY, 0),
      r(okle_pkg::OP_INS_BEFORE, 1, 2, 1, okle_pkg::KIND_EMPTY, 0),
      r(okle_pkg::OP_LIST, 0, 0, 1, okle_pkg::KIND_EMPTY, 0),
      r(okle_pkg::OP_PUSH_BACK, 8'h00, 0), r(okle_pkg::OP_PUSH_BACK, 8'hff, 0),
      r(okle_pkg::OP_PUSH_FRONT, 8'h55, 0),
      r(okle_pkg::OP_INS_AFTER, 8'haa, 8'hff), r(okle_pkg::OP_INS_BEFORE, 8'h11, 8'h55),
      r(okle_pkg::OP_INS_AFTER, 8'h22, 8'h77, 1, okle_pkg::KIND_ABSENT, 0),
      r(okle_pkg::OP_DELETE, 8'h99, 0, 1, okle_pkg::KIND_ABSENT, 0),
      r(okle_pkg::OP_LIST, 0, 0),
      r(okle_pkg::OP_DELETE, 8'haa, 0, 1, okle_pkg::KIND_LASTGONE, 0),
      r(okle_pkg::OP_DELETE, 8'h11, 0, 1, okle_pkg::KIND_KEY, 8'h55),
      r(okle_pkg::OP_POP_BACK, 0, 0, 1, okle_pkg::KIND_KEY, 8'hff),
      r(okle_pkg::OP_POP_FRONT, 0, 0, 1, okle_pkg::KIND_KEY, 8'h55),
      r(okle_pkg::OP_POP_FRONT, 0, 0, 1, okle_pkg::KIND_KEY, 8'h00),
      r(okle_pkg::OP_LIST, 0, 0, 1, okle_pkg::KIND_EMPTY, 0)
    };
    repeat (10) @(posedge clk);
    @(negedge clk) rst <= 0;
    foreach (table_rows[n]) begin
      // a typed row waits until earlier results are out, so its beat lines up
      if (table_rows[n].typed) begin
        if (pending.size() != 0) begin
          in_valid <= 0;
          while (pending.size() != 0) @(negedge clk);
        end
        typed_q.push_back(mk(table_rows[n].kind, table_rows[n].key, 1));
      end
      send_beat(table_rows[n].op, table_rows[n].item, table_rows[n].anchor);
    end
    drain();

    // fill to capacity, overflow through pushes and inserts, full list, then empty out
    for (int i = 0; i < CAP; i++) send_beat(okle_pkg::OP_PUSH_BACK, 8'(i * 4 + 1), 0);
    send_beat(okle_pkg::OP_PUSH_FRONT, 8'h7e, 0);
    send_beat(okle_pkg::OP_PUSH_BACK, 8'h7e, 0);
    send_beat(okle_pkg::OP_INS_AFTER, 8'h7e, 8'h01);
    send_beat(okle_pkg::OP_INS_BEFORE, 8'h7e, 8'hfd);
    send_beat(okle_pkg::OP_INS_AFTER, 8'h7e, 8'h02);
    send_beat(okle_pkg::OP_LIST, 0, 0);
    send_beat(okle_pkg::OP_DELETE, 8'hfd, 0);
    send_beat(okle_pkg::OP_INS_BEFORE, 8'h80, 8'hf9);
    while (seq_keys.size() > 0)
      send_beat($urandom_range(1) ? okle_pkg::OP_POP_BACK : okle_pkg::OP_POP_FRONT, 0, 0);

    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 15 : (phase == 1) ? 86 : 0;
      recv_idle_pct = (phase == 0) ? 86 : (phase == 1) ? 15 : 0;
      for (int i = 0; i < 100; i++) begin
        random_beat();
        if (i == 50) drain();
      end
    end
    recv_idle_pct = 0;
    drain();
    $display("ran %0d items, %0d result beats, %0d list walks, %0d full drops",
             items_sent, beats_seen, lists_seen, fulls_seen);
    if (mismatches == 0) $display("PASSED: all results match");
    else begin
      $display("%0d mismatches", mismatches);
      $display("FAILED: results differ");
    end
    $finish;
  end
endmodule
